// File: hdl/wrns_pkg.sv
// Shared types, constants and helpers for the wind and rumble noise synthesizer.
`timescale 1ns / 1ps

package wrns_pkg;

    // Default filter state width, signed Q1.(FILTER_WIDTH-1)
    localparam int FILTER_WIDTH_DEF = 24;

    // Seed of the xorshift32 noise register
    localparam logic [31:0] NOISE_SEED = 32'h9e3779b9;

    // Serial multiplier geometry: 4-bit digits, up to 24-bit multiplier
    localparam int DIGIT_W = 4;
    localparam int MPLIER_W = 24;
    localparam int NDIG_W = 3;
    localparam logic [NDIG_W-1:0] NDIG_LONG = NDIG_W'(MPLIER_W / DIGIT_W);
    localparam logic [NDIG_W-1:0] NDIG_SHORT = NDIG_W'(16 / DIGIT_W);

    // Signed difference of two 24-bit glide values
    localparam int GLIDE_DIFF_W = 25;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GLIDE_COEF  = 3'd0,
        REG_SOFT_COEF   = 3'd1,
        REG_BRIGHT_COEF = 3'd2,
        REG_RUMBLE_COEF = 3'd3,
        REG_SOFT_WEIGHT = 3'd4,
        REG_WIND_GAIN   = 3'd5,
        REG_RUMBLE_GAIN = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] glide_coef;
        logic [15:0] soft_coef;
        logic [15:0] bright_coef;
        logic [15:0] rumble_coef;
        logic [15:0] soft_weight;
        logic [15:0] wind_gain;
        logic [17:0] rumble_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        glide_coef:  16'd39,
        soft_coef:   16'd3932,
        bright_coef: 16'd26214,
        rumble_coef: 16'd786,
        soft_weight: 16'd42598,
        wind_gain:   16'd27000,
        rumble_gain: 18'd120000
    };

    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
        logic               clipped;
    } result_t;

    // Multiplicand width: wide enough for a filter difference and a glide difference
    function automatic int mcand_width(input int fw);
        return (fw + 1 > GLIDE_DIFF_W) ? fw + 1 : GLIDE_DIFF_W;
    endfunction

endpackage

// File: hdl/wind_rumble_noise_synth_top.sv
// Top level of the wind and rumble noise synthesizer: ports, configuration registers, output register.
`timescale 1ns / 1ps

// Each request transfer on s_ yields one signed 16-bit sample on m_. The block takes one
// request at a time: a sample occupies the shared 4-bit-per-cycle multiplier for eleven
// products (six 4-digit, five 6-digit, each with an issue and a write-back step). A finished
// sample sits in the output register, and the next request is taken while it waits there.
// Configuration writes are taken in any cycle on the cfg_ port and should only be issued
// while no request is in flight.

module wind_rumble_noise_synth_top #(
    parameter int FILTER_WIDTH = wrns_pkg::FILTER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [15:0]                      s_wind_target,
    input  logic [15:0]                      s_rumble_target,
    input  logic                             s_block_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_sample,
    output logic                             m_clipped,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wrns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wrns_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wrns_pkg::*;

    cfg_t               cfg_reg;
    logic               last_hold_reg;
    logic               m_valid_reg;
    logic signed [15:0] m_sample_reg;
    logic               m_clipped_reg;
    logic               m_last_reg;

    logic               in_xfer;
    logic               out_free;
    logic               seq_idle;
    logic [15:0]        noise;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GLIDE_COEF:  cfg_reg.glide_coef <= cfg_data[15:0];
                REG_SOFT_COEF:   cfg_reg.soft_coef <= cfg_data[15:0];
                REG_BRIGHT_COEF: cfg_reg.bright_coef <= cfg_data[15:0];
                REG_RUMBLE_COEF: cfg_reg.rumble_coef <= cfg_data[15:0];
                REG_SOFT_WEIGHT: cfg_reg.soft_weight <= cfg_data[15:0];
                REG_WIND_GAIN:   cfg_reg.wind_gain <= cfg_data[15:0];
                REG_RUMBLE_GAIN: cfg_reg.rumble_gain <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign s_ready = seq_idle;
    assign in_xfer = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            last_hold_reg <= s_block_end;
        end
    end

    wrns_xorshift u_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_xfer),
        .noise   (noise)
    );

    wrns_seq #(
        .FILTER_WIDTH (FILTER_WIDTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (in_xfer),
        .wind_target   (s_wind_target),
        .rumble_target (s_rumble_target),
        .noise         (noise),
        .cfg           (cfg_reg),
        .take          (out_free),
        .idle          (seq_idle),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid && out_free) begin
            m_valid_reg <= 1'b1;
            m_sample_reg <= result.sample;
            m_clipped_reg <= result.clipped;
            m_last_reg <= last_hold_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_clipped = m_clipped_reg;
    assign m_last = m_last_reg;

endmodule

// File: hdl/wrns_xorshift.sv
// xorshift32 white noise register, advanced once per accepted sample request.
`timescale 1ns / 1ps

module wrns_xorshift (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    output logic [15:0] noise
);
    import wrns_pkg::*;

    logic [31:0] state_reg;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] state_next;

    always_comb begin
        s1 = state_reg ^ (state_reg << 13);
        s2 = s1 ^ (s1 >> 17);
        state_next = s2 ^ (s2 << 5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NOISE_SEED;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    assign noise = state_reg[15:0];

endmodule

// File: hdl/wrns_digit_mul.sv
// Digit-serial signed-by-unsigned multiplier, one 4-bit multiplier digit per cycle, LSB first.
`timescale 1ns / 1ps

module wrns_digit_mul #(
    parameter int MCAND_W = wrns_pkg::GLIDE_DIFF_W
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic signed [MCAND_W-1:0]                    mcand,
    input  logic [wrns_pkg::MPLIER_W-1:0]                mplier,
    input  logic [wrns_pkg::NDIG_W-1:0]                  ndig,
    output logic signed [MCAND_W+wrns_pkg::DIGIT_W-1:0]  hi,
    output logic [wrns_pkg::MPLIER_W-1:0]                lo,
    output logic                                         done
);
    import wrns_pkg::*;

    localparam int HI_W = MCAND_W + DIGIT_W;

    logic signed [MCAND_W-1:0] a_reg;
    logic [MPLIER_W-1:0]       b_reg;
    logic [NDIG_W-1:0]         cnt_reg;
    logic signed [HI_W-1:0]    hi_reg;
    logic [MPLIER_W-1:0]       lo_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic signed [HI_W-1:0]    a_ext;
    logic signed [HI_W-1:0]    dig_ext;
    logic signed [HI_W-1:0]    sum_next;

    // |hi| stays below |a|, so hi + a*digit fits in HI_W bits
    always_comb begin
        a_ext = HI_W'(a_reg);
        dig_ext = {{(HI_W-DIGIT_W){1'b0}}, b_reg[DIGIT_W-1:0]};
        sum_next = hi_reg + a_ext * dig_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == NDIG_W'(1));
            if (start) begin
                a_reg <= mcand;
                b_reg <= mplier;
                hi_reg <= '0;
                lo_reg <= '0;
                cnt_reg <= ndig;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // {hi, lo} shifts right one digit: low bits of the product collect in lo
                hi_reg <= sum_next >>> DIGIT_W;
                lo_reg <= {sum_next[DIGIT_W-1:0], lo_reg[MPLIER_W-1:DIGIT_W]};
                b_reg <= b_reg >> DIGIT_W;
                cnt_reg <= cnt_reg - NDIG_W'(1);
                if (cnt_reg == NDIG_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // After n digits: hi = floor(product / 2^(4n)); with all six digits {hi, lo} is the product
    assign hi = hi_reg;
    assign lo = lo_reg;
    assign done = done_reg;

endmodule

// File: hdl/wrns_seq.sv
// Per-sample sequencer: glide, filter and mix state, eleven products on the shared multiplier.
`timescale 1ns / 1ps

module wrns_seq #(
    parameter int FILTER_WIDTH = wrns_pkg::FILTER_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [15:0]       wind_target,
    input  logic [15:0]       rumble_target,
    input  logic [15:0]       noise,
    input  wrns_pkg::cfg_t    cfg,
    input  logic              take,
    output logic              idle,
    output wrns_pkg::result_t result
);
    import wrns_pkg::*;

    localparam int FW = FILTER_WIDTH;
    localparam int MCAND_W = mcand_width(FW);
    localparam int HI_W = MCAND_W + DIGIT_W;
    localparam int PROD_W = HI_W + MPLIER_W;
    // wind term FW+16 bits, rumble term FW+18 bits, plus one for their sum
    localparam int SUM_W = FW + 19;
    localparam int Q_W = SUM_W - (FW - 1);
    localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << (FW - 1)) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_RUN,
        S_HOLD
    } state_t;

    typedef enum logic [3:0] {
        OP_WIND_GLIDE,
        OP_RUMBLE_GLIDE,
        OP_SOFT,
        OP_BRIGHT,
        OP_RUMBLE_LP,
        OP_MIX,
        OP_WIND_SQ,
        OP_WIND_LEVEL,
        OP_WIND_GAIN,
        OP_RUMBLE_LEVEL,
        OP_RUMBLE_GAIN
    } op_t;

    state_t                  state_reg;
    op_t                     op_reg;
    logic [15:0]             wt_reg;
    logic [15:0]             rt_reg;
    logic [23:0]             wg_reg;
    logic [23:0]             rg_reg;
    logic signed [FW-1:0]    soft_reg;
    logic signed [FW-1:0]    bright_reg;
    logic signed [FW-1:0]    rlp_reg;
    logic signed [FW-1:0]    mix_reg;
    logic signed [FW-1:0]    term_reg;
    logic [23:0]             g2_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [FW-1:0]      white;
    logic signed [MCAND_W-1:0] mcand;
    logic [MPLIER_W-1:0]       mplier;
    logic [NDIG_W-1:0]         ndig;
    logic                      mul_start;
    logic signed [HI_W-1:0]    mul_hi;
    logic [MPLIER_W-1:0]       mul_lo;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [SUM_W-1:0]   prod_sum;

    logic [SUM_W-1:0]          sum_adj;
    logic [Q_W-1:0]            quot;
    logic                      sat_hi;
    logic                      sat_lo;

    // low 16 noise bits offset by 32768, scaled to filter format
    assign white = {~noise[15], noise[14:0], {(FW-16){1'b0}}};

    always_comb begin
        mcand = '0;
        mplier = '0;
        ndig = NDIG_SHORT;
        case (op_reg)
            OP_WIND_GLIDE: begin
                mcand = MCAND_W'({wt_reg, 8'h00}) - MCAND_W'(wg_reg);
                mplier = MPLIER_W'(cfg.glide_coef);
            end
            OP_RUMBLE_GLIDE: begin
                mcand = MCAND_W'({rt_reg, 8'h00}) - MCAND_W'(rg_reg);
                mplier = MPLIER_W'(cfg.glide_coef);
            end
            OP_SOFT: begin
                mcand = MCAND_W'(white) - MCAND_W'(soft_reg);
                mplier = MPLIER_W'(cfg.soft_coef);
            end
            OP_BRIGHT: begin
                mcand = MCAND_W'(white) - MCAND_W'(bright_reg);
                mplier = MPLIER_W'(cfg.bright_coef);
            end
            OP_RUMBLE_LP: begin
                mcand = MCAND_W'(white) - MCAND_W'(rlp_reg);
                mplier = MPLIER_W'(cfg.rumble_coef);
            end
            OP_MIX: begin
                // soft*w + bright*(1-w) == bright + (soft - bright)*w
                mcand = MCAND_W'(soft_reg) - MCAND_W'(bright_reg);
                mplier = MPLIER_W'(cfg.soft_weight);
            end
            OP_WIND_SQ: begin
                mcand = MCAND_W'(wg_reg);
                mplier = wg_reg;
                ndig = NDIG_LONG;
            end
            OP_WIND_LEVEL: begin
                mcand = MCAND_W'(mix_reg);
                mplier = g2_reg;
                ndig = NDIG_LONG;
            end
            OP_WIND_GAIN: begin
                mcand = MCAND_W'(term_reg);
                mplier = MPLIER_W'(cfg.wind_gain);
                ndig = NDIG_LONG;
            end
            OP_RUMBLE_LEVEL: begin
                mcand = MCAND_W'(rlp_reg);
                mplier = rg_reg;
                ndig = NDIG_LONG;
            end
            OP_RUMBLE_GAIN: begin
                mcand = MCAND_W'(term_reg);
                mplier = MPLIER_W'(cfg.rumble_gain);
                ndig = NDIG_LONG;
            end
            default: begin
                mcand = '0;
            end
        endcase
    end

    assign mul_start = (state_reg == S_ISSUE);

    wrns_digit_mul #(
        .MCAND_W (MCAND_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mcand),
        .mplier  (mplier),
        .ndig    (ndig),
        .hi      (mul_hi),
        .lo      (mul_lo),
        .done    (mul_done)
    );

    assign prod_full = {mul_hi, mul_lo};
    assign prod_sum = prod_full[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= OP_WIND_GLIDE;
            wg_reg <= '0;
            rg_reg <= '0;
            soft_reg <= '0;
            bright_reg <= '0;
            rlp_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        wt_reg <= wind_target;
                        rt_reg <= rumble_target;
                        op_reg <= OP_WIND_GLIDE;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    if (mul_done) begin
                        case (op_reg)
                            OP_WIND_GLIDE:   wg_reg <= wg_reg + mul_hi[23:0];
                            OP_RUMBLE_GLIDE: rg_reg <= rg_reg + mul_hi[23:0];
                            OP_SOFT:         soft_reg <= soft_reg + mul_hi[FW-1:0];
                            OP_BRIGHT:       bright_reg <= bright_reg + mul_hi[FW-1:0];
                            OP_RUMBLE_LP:    rlp_reg <= rlp_reg + mul_hi[FW-1:0];
                            OP_MIX:          mix_reg <= bright_reg + mul_hi[FW-1:0];
                            OP_WIND_SQ:      g2_reg <= mul_hi[23:0];
                            OP_WIND_LEVEL:   term_reg <= mul_hi[FW-1:0];
                            OP_WIND_GAIN:    sum_reg <= prod_sum;
                            OP_RUMBLE_LEVEL: term_reg <= mul_hi[FW-1:0];
                            OP_RUMBLE_GAIN:  sum_reg <= sum_reg + prod_sum;
                            default: begin
                                sum_reg <= sum_reg;
                            end
                        endcase
                        if (op_reg == OP_RUMBLE_GAIN) begin
                            state_reg <= S_HOLD;
                        end else begin
                            op_reg <= op_t'(op_reg + 4'd1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_HOLD: begin
                    if (take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        sum_adj = sum_reg[SUM_W-1] ? (sum_reg + TRUNC_BIAS) : sum_reg;
        quot = sum_adj[SUM_W-1:FW-1];
        sat_hi = !quot[Q_W-1] && (|quot[Q_W-2:15]);
        sat_lo = quot[Q_W-1] && !(&quot[Q_W-2:15]);
    end

    always_comb begin
        result.valid = (state_reg == S_HOLD);
        result.clipped = sat_hi || sat_lo;
        if (sat_hi) begin
            result.sample = 16'sh7fff;
        end else if (sat_lo) begin
            result.sample = 16'sh8000;
        end else begin
            result.sample = quot[15:0];
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// File: tb/tb_wind_rumble_noise_synth_top.sv
// Self-checking testbench for the wind and rumble noise synthesizer top level.
`timescale 1ns / 1ps

module tb_wind_rumble_noise_synth_top;
    import wrns_pkg::*;

    localparam int FW = FILTER_WIDTH_DEF;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;  // unmapped index, also filler
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 241;
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1200;
    localparam int PRESSURE_AT = 400;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam longint FULL16 = (1 << 16) - 1;
    localparam longint FULL18 = (1 << CFG_DATA_W) - 1;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [15:0]             wind_t;
        logic [15:0]             rumble_t;
        logic                    blk_end;
        logic                    typed;
        logic signed [15:0]      exp_sample;
        logic                    exp_clip;
    } dir_row_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
        logic               last;
    } sample_exp_t;

    localparam int DIR_LEN = 39;
    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        // silent from reset: both glides start at zero
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'h0000, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_GLIDE_COEF, 18'h0ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'h0000, 1'b1, 1'b0, 16'sd0, 1'b0},
        // full gains: drive into saturation
        '{ROW_CFG, REG_WIND_GAIN, 18'h0ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_RUMBLE_GAIN, 18'h3ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        // bright filter alone
        '{ROW_CFG, REG_SOFT_WEIGHT, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_SOFT_WEIGHT, 18'h0ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        // zero coefficients freeze their filters
        '{ROW_CFG, REG_SOFT_COEF, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_BRIGHT_COEF, 18'h0ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_RUMBLE_COEF, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'sd0, 1'b0},
        // frozen glides keep full volume with zero targets
        '{ROW_CFG, REG_GLIDE_COEF, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'sd0, 1'b0},
        // upper data bits dropped on 16-bit registers
        '{ROW_CFG, REG_SOFT_COEF, 18'h30001, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_RUMBLE_COEF, 18'h0ffff, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_WIND_GAIN, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_RUMBLE_GAIN, 18'h00000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        // both gains zero: silent
        '{ROW_REQ, REG_NONE, 18'h00000, 16'hffff, 16'hffff, 1'b0, 1'b1, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'sd0, 1'b0},
        '{ROW_CFG, REG_GLIDE_COEF, 18'h00001, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_WIND_GAIN, 18'h21234, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_CFG, REG_RUMBLE_GAIN, 18'h00001, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h1234, 16'hfedc, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{ROW_REQ, REG_NONE, 18'h00000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'sd0, 1'b0}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_wind_target = '0;
    logic [15:0] s_rumble_target = '0;
    logic s_block_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_sample;
    logic m_clipped;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    cfg_t cfg_shadow = CFG_RESET;
    logic [31:0] noise_reg = NOISE_SEED;
    longint soft_st = 0, bright_st = 0, rumble_st = 0;
    longint wind_gl = 0, rumble_gl = 0;

    sample_exp_t sample_q[$];
    int mismatches = 0;
    int samples_seen = 0;
    int items_sent = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic no_idle = 1'b0;

    wind_rumble_noise_synth_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_wind_target   (s_wind_target),
        .s_rumble_target (s_rumble_target),
        .s_block_end     (s_block_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_clipped       (m_clipped),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one-pole step: x + floor((target - x) * coef / 2^16)
    function automatic longint glide_toward(input longint x, input longint target,
                                            input longint coef);
        return x + (((target - x) * coef) >>> 16);
    endfunction

    function automatic sample_exp_t synth_next_sample(input logic [15:0] wind_t,
                                                      input logic [15:0] rumble_t,
                                                      input logic blk_end);
        longint white, mix, g2, wind_term, rumble_term, sum;
        sample_exp_t res;
        // targets widen from Q0.16 to the Q0.24 glide format
        wind_gl = glide_toward(wind_gl, longint'(wind_t) * 256,
                               longint'(cfg_shadow.glide_coef));
        rumble_gl = glide_toward(rumble_gl, longint'(rumble_t) * 256,
                                 longint'(cfg_shadow.glide_coef));
        noise_reg = noise_reg ^ (noise_reg << 13);
        noise_reg = noise_reg ^ (noise_reg >> 17);
        noise_reg = noise_reg ^ (noise_reg << 5);
        white = (longint'(noise_reg[15:0]) - 32768) * (longint'(1) << (FW - 16));
        soft_st = glide_toward(soft_st, white, longint'(cfg_shadow.soft_coef));
        bright_st = glide_toward(bright_st, white, longint'(cfg_shadow.bright_coef));
        rumble_st = glide_toward(rumble_st, white, longint'(cfg_shadow.rumble_coef));
        mix = (soft_st * longint'(cfg_shadow.soft_weight)
               + bright_st * (65536 - longint'(cfg_shadow.soft_weight))) >>> 16;
        g2 = (wind_gl * wind_gl) >>> 24;
        wind_term = ((mix * g2) >>> 24) * longint'(cfg_shadow.wind_gain);
        rumble_term = ((rumble_st * rumble_gl) >>> 24) * longint'(cfg_shadow.rumble_gain);
        sum = wind_term + rumble_term;
        // truncate toward zero, not floor
        sum = (sum < 0) ? -((-sum) >>> (FW - 1)) : (sum >>> (FW - 1));
        res.clipped = 1'b0;
        if (sum < -32768) begin
            sum = -32768;
            res.clipped = 1'b1;
        end
        if (sum > 32767) begin
            sum = 32767;
            res.clipped = 1'b1;
        end
        res.sample = sum[15:0];
        res.last = blk_end;
        return res;
    endfunction

    function automatic logic [15:0] pick_target();
        int r;
        r = $urandom_range(7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hffff;
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_request(input logic [15:0] wind_t, input logic [15:0] rumble_t,
                                input logic blk_end, input logic typed,
                                input logic signed [15:0] typed_sample,
                                input logic typed_clip);
        sample_exp_t want;
        while (!no_idle && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_wind_target <= wind_t;
        s_rumble_target <= rumble_t;
        s_block_end <= blk_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = synth_next_sample(wind_t, rumble_t, blk_end);
        if (typed) begin
            want.sample = typed_sample;
            want.clipped = typed_clip;
        end
        sample_q.push_back(want);
        items_sent++;
    endtask

    // registers change only with nothing in flight
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_GLIDE_COEF:  cfg_shadow.glide_coef = data[15:0];
            REG_SOFT_COEF:   cfg_shadow.soft_coef = data[15:0];
            REG_BRIGHT_COEF: cfg_shadow.bright_coef = data[15:0];
            REG_RUMBLE_COEF: cfg_shadow.rumble_coef = data[15:0];
            REG_SOFT_WEIGHT: cfg_shadow.soft_weight = data[15:0];
            REG_WIND_GAIN:   cfg_shadow.wind_gain = data[15:0];
            REG_RUMBLE_GAIN: cfg_shadow.rumble_gain = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin : drain_results
        sample_exp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                samples_seen++;
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample %0d clipped %0b last %0b",
                             $time, m_sample, m_clipped, m_last);
                    mismatches++;
                end else begin
                    want = sample_q.pop_front();
                    if (m_sample !== want.sample) begin
                        $display("%0t: sample expected %0d actual %0d",
                                 $time, want.sample, m_sample);
                        mismatches++;
                    end
                    if (m_clipped !== want.clipped) begin
                        $display("%0t: clipped expected %0b actual %0b",
                                 $time, want.clipped, m_clipped);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, m_last);
                        mismatches++;
                    end
                end
                if (samples_seen == PRESSURE_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_wind_rumble_noise_synth_top: errors");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t row;
        logic [15:0] wind_t, rumble_t;
        logic blk_end;
        longint lo, hi, val;
        int buf_len, sent;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_LEN; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_request(row.wind_t, row.rumble_t, row.blk_end, row.typed,
                             row.exp_sample, row.exp_clip);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            for (int idx = REG_GLIDE_COEF; idx <= REG_RUMBLE_GAIN; idx++) begin
                lo = (idx <= REG_RUMBLE_COEF) ? 1 : 0;
                hi = (idx == REG_RUMBLE_GAIN) ? FULL18 : FULL16;
                case ($urandom_range(5))
                    0: val = lo;
                    1: val = hi;
                    default: val = $urandom_range(int'(hi), int'(lo));
                endcase
                // first phase runs on power-up settings
                if (phase == 0) begin
                    case (idx)
                        REG_GLIDE_COEF:  val = CFG_RESET.glide_coef;
                        REG_SOFT_COEF:   val = CFG_RESET.soft_coef;
                        REG_BRIGHT_COEF: val = CFG_RESET.bright_coef;
                        REG_RUMBLE_COEF: val = CFG_RESET.rumble_coef;
                        REG_SOFT_WEIGHT: val = CFG_RESET.soft_weight;
                        REG_WIND_GAIN:   val = CFG_RESET.wind_gain;
                        default:         val = CFG_RESET.rumble_gain;
                    endcase
                end
                // stray upper bits on the 16-bit registers
                if (idx != REG_RUMBLE_GAIN)
                    val = val | (longint'($urandom_range(3)) << 16);
                write_reg(idx[CFG_INDEX_W-1:0], val[CFG_DATA_W-1:0]);
            end
            write_reg(REG_NONE, CFG_DATA_W'($urandom_range(int'(FULL18))));

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                buf_len = $urandom_range(48, 1);
                wind_t = pick_target();
                rumble_t = pick_target();
                for (int k = 0; k < buf_len && sent < PHASE_ITEMS; k++) begin
                    if ($urandom_range(7) == 0) wind_t = pick_target();
                    if ($urandom_range(7) == 0) rumble_t = pick_target();
                    blk_end = (k == buf_len - 1);
                    if ($urandom_range(19) == 0) blk_end = !blk_end;
                    no_idle = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
                    send_request(wind_t, rumble_t, blk_end, 1'b0, 16'sd0, 1'b0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_wind_rumble_noise_synth_top: clean");
        else
            $display("tb_wind_rumble_noise_synth_top: errors");
        $finish;
    end

endmodule
